FILE: src/fmpsd_pkg.sv
package fmpsd_pkg;

   // Width of the frame counters and of the proceed and stop limits.
   localparam int LIM_W = 8;

   // Width of a configuration register index.
   localparam int CSR_IDX_W = 2;

   typedef logic [1:0] decision_type;

   localparam decision_type DEC_NONE    = 2'd0;
   localparam decision_type DEC_PROCEED = 2'd1;
   localparam decision_type DEC_STOP    = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_THRESHOLD_A = 2'd0;
   localparam csr_index_type CSR_THRESHOLD_B = 2'd1;
   localparam csr_index_type CSR_PROCEED_LIM = 2'd2;
   localparam csr_index_type CSR_STOP_LIM    = 2'd3;

   typedef struct packed {
      logic [LIM_W-1:0] proceed_limit;
      logic [LIM_W-1:0] stop_limit;
   } limits_type;

endpackage

FILE: src/frame_mean_proceed_stop_detector_unit.sv
// Channel  Ports                                    Direction  Word
// req      req_valid/req_ready, sample_a/b, end     in         one sample pair
// rsp      rsp_valid/rsp_ready, decision, flags     out        one frame verdict
// csr      csr_valid/csr_ready, csr_index, wdata    in         one register write
//
// One sample pair is accepted every cycle but for the stall below. The verdict of a frame
// goes from its closing pair through the frame register and threshold multipliers to the
// decision in the result register. Reset clears all valid flags, the running sums and frame
// counters, and loads the register defaults. While a result waits, samples keep flowing
// into the accumulator; intake stops only when a closing pair reaches the input register
// while the frame and product registers both hold closed frames behind the waiting verdict.
module frame_mean_proceed_stop_detector_unit #(
   parameter int MAX_FRAME_LEN = 1024,
   parameter int SAMPLE_WIDTH  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Sample pairs in.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [SAMPLE_WIDTH-1:0]            req_sample_a,
   input  logic [SAMPLE_WIDTH-1:0]            req_sample_b,
   input  logic                               req_frame_end,
   // Frame verdicts out.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fmpsd_pkg::decision_type            rsp_decision,
   output logic                               rsp_frame_passed,
   output logic                               rsp_frame_overflow,
   // Register writes.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  fmpsd_pkg::csr_index_type           csr_index,
   input  logic [SAMPLE_WIDTH-1:0]            csr_wdata
);
   import fmpsd_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
   localparam int SUM_W = SAMPLE_WIDTH + CNT_W;

   // Configuration registers. Writes are taken at once, every cycle.
   logic [SAMPLE_WIDTH-1:0] thr_a_ff, thr_b_ff;
   limits_type              limits_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_a_ff                <= '0;
         thr_b_ff                <= '0;
         limits_ff.proceed_limit <= LIM_W'(3);
         limits_ff.stop_limit    <= LIM_W'(5);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD_A: thr_a_ff                <= csr_wdata;
            CSR_THRESHOLD_B: thr_b_ff                <= csr_wdata;
            CSR_PROCEED_LIM: limits_ff.proceed_limit <= csr_wdata[LIM_W-1:0];
            CSR_STOP_LIM:    limits_ff.stop_limit    <= csr_wdata[LIM_W-1:0];
            default:         ;
         endcase
      end
   end

   // Input register. It empties whenever the accumulator takes its word, so a
   // new pair can enter in the same cycle.
   logic                    a_valid_ff, a_valid_in;
   logic [SAMPLE_WIDTH-1:0] a_sample_a_ff, a_sample_b_ff;
   logic                    a_frame_end_ff;
   logic                    a_take;
   logic                    req_take;

   assign req_ready = !a_valid_ff || a_take;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (a_take) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_sample_a_ff  <= req_sample_a;
         a_sample_b_ff  <= req_sample_b;
         a_frame_end_ff <= req_frame_end;
      end
   end

   // Closed frame between the accumulator and the judge.
   logic             frm_valid, frm_ready;
   logic [SUM_W-1:0] frm_sum_a, frm_sum_b;
   logic [CNT_W-1:0] frm_count;
   logic             frm_overflow;

   fmpsd_accum #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN),
      .SAMPLE_WIDTH  (SAMPLE_WIDTH)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .a_valid      (a_valid_ff),
      .a_sample_a   (a_sample_a_ff),
      .a_sample_b   (a_sample_b_ff),
      .a_frame_end  (a_frame_end_ff),
      .a_take       (a_take),
      .frm_valid    (frm_valid),
      .frm_ready    (frm_ready),
      .frm_sum_a    (frm_sum_a),
      .frm_sum_b    (frm_sum_b),
      .frm_count    (frm_count),
      .frm_overflow (frm_overflow)
   );

   // The judge compares each sum against threshold times count and keeps the
   // cumulative pass and fail counts that drive proceed and stop.
   fmpsd_judge #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN),
      .SAMPLE_WIDTH  (SAMPLE_WIDTH)
   ) u_judge (
      .clock              (clock),
      .reset              (reset),
      .threshold_a        (thr_a_ff),
      .threshold_b        (thr_b_ff),
      .limits             (limits_ff),
      .frm_valid          (frm_valid),
      .frm_ready          (frm_ready),
      .frm_sum_a          (frm_sum_a),
      .frm_sum_b          (frm_sum_b),
      .frm_count          (frm_count),
      .frm_overflow       (frm_overflow),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_decision       (rsp_decision),
      .rsp_frame_passed   (rsp_frame_passed),
      .rsp_frame_overflow (rsp_frame_overflow)
   );

endmodule

FILE: src/fmpsd_accum.sv
module fmpsd_accum #(
   parameter int MAX_FRAME_LEN = 1024,
   parameter int SAMPLE_WIDTH  = 16,
   localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1),
   localparam int SUM_W = SAMPLE_WIDTH + CNT_W
) (
   input  logic                    clock,
   input  logic                    reset,
   // Input register side.
   input  logic                    a_valid,
   input  logic [SAMPLE_WIDTH-1:0] a_sample_a,
   input  logic [SAMPLE_WIDTH-1:0] a_sample_b,
   input  logic                    a_frame_end,
   output logic                    a_take,
   // Closed frame toward the judge.
   output logic                    frm_valid,
   input  logic                    frm_ready,
   output logic [SUM_W-1:0]        frm_sum_a,
   output logic [SUM_W-1:0]        frm_sum_b,
   output logic [CNT_W-1:0]        frm_count,
   output logic                    frm_overflow
);
   import fmpsd_pkg::*;

   logic             [SUM_W-1:0] sum_a_ff, sum_a_in;
   logic             [SUM_W-1:0] sum_b_ff, sum_b_in;
   logic             [CNT_W-1:0] count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic                         keep;
   logic                         b_free;
   logic                         frm_valid_ff, frm_valid_in;
   logic             [SUM_W-1:0] frm_sum_a_ff, frm_sum_b_ff;
   logic             [CNT_W-1:0] frm_count_ff;
   logic                         frm_ovf_ff;

   // A sample that does not close a frame never waits on the frame register.
   assign b_free = !frm_valid_ff || frm_ready;
   assign a_take = a_valid && (!a_frame_end || b_free);

   assign keep = count_ff < CNT_W'(MAX_FRAME_LEN);

   always_comb begin
      if (keep) begin
         sum_a_in = sum_a_ff + {{CNT_W{a_sample_a[SAMPLE_WIDTH-1]}}, a_sample_a};
         sum_b_in = sum_b_ff + {{CNT_W{a_sample_b[SAMPLE_WIDTH-1]}}, a_sample_b};
         count_in = count_ff + CNT_W'(1);
      end else begin
         sum_a_in = sum_a_ff;
         sum_b_in = sum_b_ff;
         count_in = count_ff;
      end
      ovf_in = ovf_ff || !keep;

      if (a_take && a_frame_end) begin
         frm_valid_in = 1'b1;
      end else if (frm_ready) begin
         frm_valid_in = 1'b0;
      end else begin
         frm_valid_in = frm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         frm_valid_ff <= 1'b0;
      end else begin
         frm_valid_ff <= frm_valid_in;
         if (a_take) begin
            if (a_frame_end) begin
               sum_a_ff <= '0;
               sum_b_ff <= '0;
               count_ff <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               sum_a_ff <= sum_a_in;
               sum_b_ff <= sum_b_in;
               count_ff <= count_in;
               ovf_ff   <= ovf_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_take && a_frame_end) begin
         frm_sum_a_ff <= sum_a_in;
         frm_sum_b_ff <= sum_b_in;
         frm_count_ff <= count_in;
         frm_ovf_ff   <= ovf_in;
      end
   end

   assign frm_valid    = frm_valid_ff;
   assign frm_sum_a    = frm_sum_a_ff;
   assign frm_sum_b    = frm_sum_b_ff;
   assign frm_count    = frm_count_ff;
   assign frm_overflow = frm_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME_LEN))
      else $error("frame sample count beyond maximum frame length");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == CNT_W'(MAX_FRAME_LEN))
      else $error("overflow flagged before the frame was full");

   a_frame_nonempty: assert property (@(posedge clock) disable iff (reset)
      frm_valid_ff |-> frm_count_ff != '0)
      else $error("closed frame holds no samples");

endmodule

FILE: src/fmpsd_judge.sv
module fmpsd_judge #(
   parameter int MAX_FRAME_LEN = 1024,
   parameter int SAMPLE_WIDTH  = 16,
   localparam int CNT_W  = $clog2(MAX_FRAME_LEN + 1),
   localparam int SUM_W  = SAMPLE_WIDTH + CNT_W,
   localparam int PROD_W = SAMPLE_WIDTH + CNT_W + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [SAMPLE_WIDTH-1:0]      threshold_a,
   input  logic [SAMPLE_WIDTH-1:0]      threshold_b,
   input  fmpsd_pkg::limits_type        limits,
   // Closed frame from the accumulator.
   input  logic                         frm_valid,
   output logic                         frm_ready,
   input  logic [SUM_W-1:0]             frm_sum_a,
   input  logic [SUM_W-1:0]             frm_sum_b,
   input  logic [CNT_W-1:0]             frm_count,
   input  logic                         frm_overflow,
   // Result register.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output fmpsd_pkg::decision_type      rsp_decision,
   output logic                         rsp_frame_passed,
   output logic                         rsp_frame_overflow
);
   import fmpsd_pkg::*;

   logic                     c_valid_ff, c_valid_in;
   logic signed [PROD_W-1:0] c_prod_a_ff, c_prod_b_ff;
   logic signed [SUM_W-1:0]  c_sum_a_ff, c_sum_b_ff;
   logic                     c_ovf_ff;
   logic                     d_free, c_move;
   logic                     passed;
   logic [LIM_W-1:0]         pass_ff, pass_in, fail_ff, fail_in;
   logic [LIM_W-1:0]         pass_inc, fail_inc;
   decision_type             dec_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   decision_type             rsp_decision_ff;
   logic                     rsp_passed_ff, rsp_ovf_ff;

   assign d_free    = !rsp_valid_ff || rsp_ready;
   assign c_move    = c_valid_ff && d_free;
   assign frm_ready = !c_valid_ff || d_free;

   // Product stage: threshold times sample count, one multiplier per channel.
   always_comb begin
      if (frm_valid) begin
         c_valid_in = 1'b1;
      end else if (d_free) begin
         c_valid_in = 1'b0;
      end else begin
         c_valid_in = c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (frm_valid && frm_ready) begin
         c_prod_a_ff <= PROD_W'($signed(threshold_a)) * PROD_W'($signed({1'b0, frm_count}));
         c_prod_b_ff <= PROD_W'($signed(threshold_b)) * PROD_W'($signed({1'b0, frm_count}));
         c_sum_a_ff  <= $signed(frm_sum_a);
         c_sum_b_ff  <= $signed(frm_sum_b);
         c_ovf_ff    <= frm_overflow;
      end
   end

   // Decision stage: mean test and the cumulative frame counters.
   assign passed = ($signed({c_sum_a_ff[SUM_W-1], c_sum_a_ff}) >= c_prod_a_ff) &&
                   ($signed({c_sum_b_ff[SUM_W-1], c_sum_b_ff}) >= c_prod_b_ff);

   assign pass_inc = (pass_ff == '1) ? pass_ff : pass_ff + LIM_W'(1);
   assign fail_inc = (fail_ff == '1) ? fail_ff : fail_ff + LIM_W'(1);

   always_comb begin
      pass_in = pass_ff;
      fail_in = fail_ff;
      dec_in  = DEC_NONE;
      if (passed) begin
         if (pass_inc >= limits.proceed_limit) begin
            pass_in = '0;
            fail_in = '0;
            dec_in  = DEC_PROCEED;
         end else begin
            pass_in = pass_inc;
         end
      end else begin
         if (fail_inc >= limits.stop_limit) begin
            pass_in = '0;
            fail_in = '0;
            dec_in  = DEC_STOP;
         end else begin
            fail_in = fail_inc;
         end
      end

      if (c_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= '0;
         fail_ff      <= '0;
      end else begin
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (c_move) begin
            pass_ff <= pass_in;
            fail_ff <= fail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_move) begin
         rsp_decision_ff <= dec_in;
         rsp_passed_ff   <= passed;
         rsp_ovf_ff      <= c_ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decision       = rsp_decision_ff;
   assign rsp_frame_passed   = rsp_passed_ff;
   assign rsp_frame_overflow = rsp_ovf_ff;

   a_decision_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_decision_ff == DEC_NONE || rsp_decision_ff == DEC_PROCEED ||
                        rsp_decision_ff == DEC_STOP))
      else $error("result carries an undefined decision code");

   a_decision_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_decision_ff != DEC_NONE |->
         (rsp_frame_passed == (rsp_decision_ff == DEC_PROCEED)))
      else $error("decision disagrees with the frame test");

   a_counters_cleared: assert property (@(posedge clock) disable iff (reset)
      $past(c_move) && rsp_decision_ff != DEC_NONE |-> pass_ff == '0 && fail_ff == '0)
      else $error("frame counters not cleared after a decision");

endmodule
